// ----- rtl/dsi_pkg.sv -----
// shared types and constants for the disjoint interval set insert unit
// no dependencies; used by every module of the block

package dsi_pkg;

	localparam int MAX_RANGES  = 32;
	localparam int VALUE_WIDTH = 16;
	localparam int CNT_W       = $clog2(MAX_RANGES + 1);
	localparam int STATUS_W    = 3;

	typedef enum logic [STATUS_W-1:0] {
		ST_NEW      = 3'd0,
		ST_COVERED  = 3'd1,
		ST_EXTENDED = 3'd2,
		ST_JOINED   = 3'd3,
		ST_FULL     = 3'd4,
		ST_DUMP     = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		CMD_HOLD      = 3'd0,
		CMD_EVAL      = 3'd1,
		CMD_EXT_LEFT  = 3'd2,
		CMD_JOIN      = 3'd3,
		CMD_EXT_RIGHT = 3'd4,
		CMD_INSERT    = 3'd5,
		CMD_ROTATE    = 3'd6
	} cmd_t;

	typedef struct packed {
		logic                   op;
		logic [VALUE_WIDTH-1:0] value;
	} in_word_t;

	typedef struct packed {
		status_t                status;
		logic [VALUE_WIDTH-1:0] range_start;
		logic [VALUE_WIDTH-1:0] range_end;
		logic [CNT_W-1:0]       range_count;
		logic                   empty_res;
		logic                   last;
	} out_word_t;

	// broadcast to every cell
	typedef struct packed {
		cmd_t                   op;
		logic [VALUE_WIDTH-1:0] value;
	} cell_cmd_t;

	// what a cell hands to its neighbors
	typedef struct packed {
		logic                   le;
		logic [VALUE_WIDTH-1:0] lo;
		logic [VALUE_WIDTH-1:0] hi;
	} link_t;

	// what a cell reports to the controller
	typedef struct packed {
		logic is_left;
		logic is_right;
		logic cov;
		logic adje;
		logic adjs;
	} cell_flags_t;

endpackage

// ----- rtl/dsi_cell.sv -----
// one cell of the range chain: holds one stored range and its compare flags
// depends on dsi_pkg

module dsi_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  dsi_pkg::cell_cmd_t  cmd,
	input  logic                occ,
	input  dsi_pkg::link_t      dn,
	input  dsi_pkg::link_t      up,
	output dsi_pkg::link_t      link,
	output dsi_pkg::cell_flags_t flags
);

	logic [dsi_pkg::VALUE_WIDTH-1:0] lo_q;
	logic [dsi_pkg::VALUE_WIDTH-1:0] hi_q;
	logic le_q, cov_q, adje_q, adjs_q;
	logic is_left, is_right;

	// compares without wrap at the value edges
	logic [dsi_pkg::VALUE_WIDTH:0] v_ext, v_inc, hi_inc;

	assign v_ext  = {1'b0, cmd.value};
	assign v_inc  = v_ext + 1'b1;
	assign hi_inc = {1'b0, hi_q} + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			le_q   <= 1'b0;
			cov_q  <= 1'b0;
			adje_q <= 1'b0;
			adjs_q <= 1'b0;
		end else if (cmd.op == dsi_pkg::CMD_EVAL) begin
			le_q   <= occ && (lo_q <= cmd.value);
			cov_q  <= hi_q >= cmd.value;
			adje_q <= hi_inc == v_ext;
			adjs_q <= {1'b0, lo_q} == v_inc;
		end
	end

	// left cell: last one at or below the value; right cell: the one after it
	assign is_left  = le_q && !up.le;
	assign is_right = occ && !le_q && dn.le;

	always_ff @(posedge clk) begin
		case (cmd.op)
			dsi_pkg::CMD_EXT_LEFT: begin
				if (is_left) begin
					hi_q <= cmd.value;
				end
			end
			dsi_pkg::CMD_JOIN: begin
				if (is_left) begin
					hi_q <= up.hi;
				end else if (!le_q) begin
					lo_q <= up.lo;
					hi_q <= up.hi;
				end
			end
			dsi_pkg::CMD_EXT_RIGHT: begin
				if (is_right) begin
					lo_q <= cmd.value;
				end
			end
			dsi_pkg::CMD_INSERT: begin
				if (!le_q) begin
					if (dn.le) begin
						lo_q <= cmd.value;
						hi_q <= cmd.value;
					end else begin
						lo_q <= dn.lo;
						hi_q <= dn.hi;
					end
				end
			end
			dsi_pkg::CMD_ROTATE: begin
				lo_q <= up.lo;
				hi_q <= up.hi;
			end
			default: begin
			end
		endcase
	end

	assign link  = '{le: le_q, lo: lo_q, hi: hi_q};
	assign flags = '{is_left: is_left, is_right: is_right, cov: cov_q,
		adje: adje_q, adjs: adjs_q};

endmodule

// ----- rtl/disjoint_interval_set_insert_unit.sv -----
// add: an accepted word is compared in all cells, then the update is applied,
//   result registered at the end; a new word is taken as the current add retires
// dump: the cell ring rotates once fully, waiting while the output stalls,
//   one range per cycle while free, then back to idle; empty dump: a single flagged word
// reset (arst_n low, asynchronous) clears the stored count, fsm and output valid;
//   range contents stay undefined until written
// depends on dsi_pkg and dsi_cell

module disjoint_interval_set_insert_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  dsi_pkg::in_word_t   item,
	output logic                result_valid,
	input  logic                result_stall,
	output dsi_pkg::out_word_t  result
);

	localparam int N = dsi_pkg::MAX_RANGES;

	// one-hot sequencer states
	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_EVAL  = 4'b0010,
		S_APPLY = 4'b0100,
		S_DUMP  = 4'b1000
	} fsm_t;

	fsm_t state_q, state_d;

	logic [dsi_pkg::VALUE_WIDTH-1:0] val_q;
	logic [dsi_pkg::CNT_W-1:0]       count_q, count_d;
	logic [dsi_pkg::CNT_W-1:0]       rot_q;
	logic                            out_valid_q;
	dsi_pkg::out_word_t              out_q, out_d;
	logic                            out_load;
	logic                            out_free;
	logic                            take;

	dsi_pkg::cell_cmd_t   cmd;
	dsi_pkg::link_t       lk    [N];
	dsi_pkg::link_t       dn_lk [N];
	dsi_pkg::link_t       up_lk [N];
	dsi_pkg::cell_flags_t fl    [N];
	logic [N-1:0]         occ;

	// reduced view of the left and right cells
	logic has_left, left_cov, left_adje, has_right, right_adjs;

	// output register frees when empty or when the word leaves this cycle
	assign out_free = !out_valid_q || !result_stall;

	// new word only when idle or as the current add retires
	assign item_stall = !((state_q == S_IDLE) || ((state_q == S_APPLY) && out_free));
	assign take       = item_valid && !item_stall;

	// ---------------------------------------------------------------- cell chain
	// cell 0 sees a lower neighbor that is always at or below the value;
	// the top cell wraps to cell 0 so a dump can rotate the ring
	for (genvar i = 0; i < N; i++) begin : g_cell
		assign occ[i] = dsi_pkg::CNT_W'(i) < count_q;
		if (i == 0) begin : g_first
			assign dn_lk[i] = '{le: 1'b1, lo: '0, hi: '0};
		end else begin : g_mid_dn
			assign dn_lk[i] = lk[i-1];
		end
		if (i == N - 1) begin : g_last
			assign up_lk[i] = '{le: 1'b0, lo: lk[0].lo, hi: lk[0].hi};
		end else begin : g_mid_up
			assign up_lk[i] = lk[i+1];
		end
		dsi_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.cmd   (cmd),
			.occ   (occ[i]),
			.dn    (dn_lk[i]),
			.up    (up_lk[i]),
			.link  (lk[i]),
			.flags (fl[i])
		);
	end

	// at most one cell is left and one is right, so plain or-reduction selects
	always_comb begin
		has_left   = 1'b0;
		left_cov   = 1'b0;
		left_adje  = 1'b0;
		has_right  = 1'b0;
		right_adjs = 1'b0;
		for (int i = 0; i < N; i++) begin
			has_left   = has_left   | fl[i].is_left;
			left_cov   = left_cov   | (fl[i].is_left & fl[i].cov);
			left_adje  = left_adje  | (fl[i].is_left & fl[i].adje);
			has_right  = has_right  | fl[i].is_right;
			right_adjs = right_adjs | (fl[i].is_right & fl[i].adjs);
		end
	end

	// ---------------------------------------------------------------- sequencer
	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		cmd      = '{op: dsi_pkg::CMD_HOLD, value: val_q};
		out_load = 1'b0;
		out_d    = '{status: dsi_pkg::ST_DUMP, range_start: '0, range_end: '0,
			range_count: count_q, empty_res: 1'b0, last: 1'b1};
		case (state_q)
			S_IDLE: begin
				if (take) begin
					state_d = item.op ? S_DUMP : S_EVAL;
				end
			end
			S_EVAL: begin
				cmd.op  = dsi_pkg::CMD_EVAL;
				state_d = S_APPLY;
			end
			S_APPLY: begin
				if (out_free) begin
					out_load = 1'b1;
					if (has_left && left_cov) begin
						out_d.status = dsi_pkg::ST_COVERED;
					end else if (has_left && left_adje) begin
						if (has_right && right_adjs) begin
							cmd.op       = dsi_pkg::CMD_JOIN;
							out_d.status = dsi_pkg::ST_JOINED;
							count_d      = count_q - 1'b1;
						end else begin
							cmd.op       = dsi_pkg::CMD_EXT_LEFT;
							out_d.status = dsi_pkg::ST_EXTENDED;
						end
					end else if (has_right && right_adjs) begin
						cmd.op       = dsi_pkg::CMD_EXT_RIGHT;
						out_d.status = dsi_pkg::ST_EXTENDED;
					end else if (count_q == dsi_pkg::CNT_W'(N)) begin
						out_d.status = dsi_pkg::ST_FULL;
					end else begin
						cmd.op       = dsi_pkg::CMD_INSERT;
						out_d.status = dsi_pkg::ST_NEW;
						count_d      = count_q + 1'b1;
					end
					out_d.range_count = count_d;
					if (take) begin
						state_d = item.op ? S_DUMP : S_EVAL;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_DUMP: begin
				if (count_q == '0) begin
					// empty table: a single flagged word
					if (out_free) begin
						out_load        = 1'b1;
						out_d.empty_res = 1'b1;
						state_d         = S_IDLE;
					end
				end else if (rot_q < count_q) begin
					// emit cell 0, then rotate the ring by one
					if (out_free) begin
						out_load          = 1'b1;
						out_d.range_start = lk[0].lo;
						out_d.range_end   = lk[0].hi;
						out_d.last        = rot_q == (count_q - 1'b1);
						cmd.op            = dsi_pkg::CMD_ROTATE;
					end
				end else begin
					// finish the full turn so entry order is restored
					cmd.op = dsi_pkg::CMD_ROTATE;
				end
				if ((cmd.op == dsi_pkg::CMD_ROTATE) &&
					(rot_q == dsi_pkg::CNT_W'(N - 1))) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rot_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (take) begin
				rot_q <= '0;
			end else if (cmd.op == dsi_pkg::CMD_ROTATE) begin
				rot_q <= rot_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (take) begin
			val_q <= item.value;
		end
		if (out_load) begin
			out_q <= out_d;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

// ----- rtl/dsi_checker.sv -----
// port-level checks for the disjoint interval set insert unit, bound to the top
// depends on dsi_pkg

module dsi_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               item_valid,
	input logic               item_stall,
	input dsi_pkg::in_word_t  item,
	input logic               result_valid,
	input logic               result_stall,
	input dsi_pkg::out_word_t result
);

	// stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result word changed");

	// add words are single, with zero range fields
	a_add_word: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.status != dsi_pkg::ST_DUMP) |->
		result.last && (result.range_start == '0) && (result.range_end == '0) &&
		!result.empty_res)
		else $error("add result word malformed");

	// empty dump means nothing stored
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.empty_res |->
		(result.range_count == '0) && result.last &&
		(result.status == dsi_pkg::ST_DUMP))
		else $error("empty dump word inconsistent");

	// count never exceeds table size
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |->
		(result.range_count <= dsi_pkg::CNT_W'(dsi_pkg::MAX_RANGES)))
		else $error("range count over table size");

	// stalled input word holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_stall |=> item_valid && $stable(item))
		else $error("stalled item word changed");

endmodule

bind disjoint_interval_set_insert_unit dsi_checker u_dsi_checker (.*);

// ----- sim/interval_scoreboard_pkg.sv -----
// scoreboard for the disjoint interval set insert unit: range table predictor and word checker
// depends on dsi_pkg for word types, status codes and table size

package interval_scoreboard_pkg;
	import dsi_pkg::*;

	localparam logic OP_ADD     = 1'b0;
	localparam logic OP_DUMP    = 1'b1;
	localparam int   REPORT_MAX = 10;

	class interval_scoreboard;
		logic [VALUE_WIDTH-1:0] lo_tab [MAX_RANGES];
		logic [VALUE_WIDTH-1:0] hi_tab [MAX_RANGES];
		int                     n_ranges;
		out_word_t              expected_q [$];
		int                     n_errors;

		function new();
			n_ranges = 0;
			n_errors = 0;
		endfunction

		// append one expected word at the tail
		function void expect_word(out_word_t w);
			expected_q.insert(expected_q.size(), w);
		endfunction

		// int math so value+1 and end+1 never wrap
		function status_t merge_value(int v);
			int left;
			int right;
			int i;
			left = -1;
			for (i = 0; i < n_ranges; i++) begin
				if (int'(lo_tab[i]) <= v)
					left = i;
			end
			if (left >= 0 && int'(hi_tab[left]) >= v)
				return ST_COVERED;
			right = left + 1;
			if (left >= 0 && int'(hi_tab[left]) + 1 == v) begin
				hi_tab[left] = VALUE_WIDTH'(v);
				if (right < n_ranges && int'(lo_tab[right]) == v + 1) begin
					hi_tab[left] = hi_tab[right];
					for (i = right; i + 1 < n_ranges; i++) begin
						lo_tab[i] = lo_tab[i + 1];
						hi_tab[i] = hi_tab[i + 1];
					end
					n_ranges--;
					return ST_JOINED;
				end
				return ST_EXTENDED;
			end
			if (right < n_ranges && int'(lo_tab[right]) == v + 1) begin
				lo_tab[right] = VALUE_WIDTH'(v);
				return ST_EXTENDED;
			end
			if (n_ranges >= MAX_RANGES)
				return ST_FULL;
			for (i = n_ranges; i > right; i--) begin
				lo_tab[i] = lo_tab[i - 1];
				hi_tab[i] = hi_tab[i - 1];
			end
			lo_tab[right] = VALUE_WIDTH'(v);
			hi_tab[right] = VALUE_WIDTH'(v);
			n_ranges++;
			return ST_NEW;
		endfunction

		function void note_item(in_word_t w);
			out_word_t r;
			int i;
			r = '0;
			if (w.op == OP_ADD) begin
				r.status      = merge_value(int'(w.value));
				r.range_count = CNT_W'(n_ranges);
				r.last        = 1'b1;
				expect_word(r);
			end else if (n_ranges == 0) begin
				r.status    = ST_DUMP;
				r.empty_res = 1'b1;
				r.last      = 1'b1;
				expect_word(r);
			end else begin
				for (i = 0; i < n_ranges; i++) begin
					r.status      = ST_DUMP;
					r.range_start = lo_tab[i];
					r.range_end   = hi_tab[i];
					r.range_count = CNT_W'(n_ranges);
					r.last        = (i == n_ranges - 1);
					expect_word(r);
				end
			end
		endfunction

		function void report(string what, out_word_t want, out_word_t got);
			n_errors++;
			if (n_errors <= REPORT_MAX) begin
				$display("%s: expected status %0d start %0d end %0d count %0d empty %0d last %0d",
					what, want.status, want.range_start, want.range_end, want.range_count,
					want.empty_res, want.last);
				$display("  actual status %0d start %0d end %0d count %0d empty %0d last %0d",
					got.status, got.range_start, got.range_end, got.range_count,
					got.empty_res, got.last);
			end
		endfunction

		function void check_result(out_word_t got);
			out_word_t want;
			if (expected_q.size() == 0) begin
				report("unexpected result word", '0, got);
				return;
			end
			want = expected_q.pop_front();
			if (got.status !== want.status || got.range_start !== want.range_start
				|| got.range_end !== want.range_end || got.range_count !== want.range_count
				|| got.empty_res !== want.empty_res || got.last !== want.last)
				report("result word mismatch", want, got);
		endfunction
	endclass

endpackage

// ----- sim/tb_top.sv -----
// testbench top for disjoint_interval_set_insert_unit: directed and random add/dump words
// depends on dsi_pkg, interval_scoreboard_pkg and the unit under test

module tb_top;
	import dsi_pkg::*;
	import interval_scoreboard_pkg::*;

	localparam int HALF_PERIOD    = 10;
	localparam int RESET_CYCLES   = 5;
	localparam int IDLE_PCT       = 16;
	localparam int ITEM_TARGET    = 300;
	localparam int FILL_STEPS     = 36;
	// a full dump plus margin, after the last expected word
	localparam int DRAIN_CYCLES   = MAX_RANGES + 8;
	// cycles with no word moving on either side
	localparam int WATCHDOG_LIMIT = 4000;
	localparam logic [VALUE_WIDTH-1:0] VALUE_TOP = '1;

	logic      clk          = 1'b0;
	logic      arst_n       = 1'b0;
	logic      item_valid   = 1'b0;
	logic      item_stall;
	in_word_t  item         = '0;
	logic      result_valid;
	logic      result_stall = 1'b0;
	out_word_t result;

	// calm turns off idling on both sides for one long stretch
	bit calm       = 1'b0;
	int items_sent = 0;
	interval_scoreboard sb;

	always #HALF_PERIOD clk = ~clk;

	disjoint_interval_set_insert_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	// result side: check every accepted word, then pick next cycle's stall
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			sb.check_result(result);
		result_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
	end

	// watchdog: any accepted word on either side restarts the count
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((item_valid && !item_stall) || (result_valid && !result_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("tb_top failed");
		$finish;
	end

	// offer one word, with random idle cycles in front; valid stays up
	// between back to back words and the payload holds while stalled
	task automatic send_word(input logic op, input logic [VALUE_WIDTH-1:0] v);
		in_word_t w;
		w.op    = op;
		w.value = v;
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= w;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		sb.note_item(w);
		items_sent++;
	endtask

	// adds clustered in a narrow window so neighbors meet often,
	// with some dumps, some full-range values and the two extremes
	task automatic window_phase(input int n_words);
		int span;
		int base;
		int pick;
		int k;
		span = $urandom_range(160, 24);
		base = $urandom_range(int'(VALUE_TOP) - span, 0);
		for (k = 0; k < n_words; k++) begin
			pick = $urandom_range(99);
			if (pick < 8)
				send_word(OP_DUMP, VALUE_WIDTH'($urandom));
			else if (pick < 11)
				send_word(OP_ADD, pick[0] ? VALUE_TOP : '0);
			else if (pick < 16)
				send_word(OP_ADD, VALUE_WIDTH'($urandom));
			else
				send_word(OP_ADD, VALUE_WIDTH'(base + $urandom_range(span)));
		end
	endtask

	initial begin
		int base;
		int phase;
		int k;
		sb = new();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// dump of an empty table
		send_word(OP_DUMP, '0);
		// value edges: only one order fits one reset, the seed picks it
		if ($urandom_range(1)) begin
			send_word(OP_ADD, VALUE_TOP);
			send_word(OP_ADD, '0);          // zero must not extend the top range
		end else begin
			send_word(OP_ADD, '0);
			send_word(OP_ADD, VALUE_TOP);   // top must not touch the range at zero
		end
		send_word(OP_ADD, '0);              // covered
		send_word(OP_ADD, VALUE_TOP);       // covered
		send_word(OP_ADD, 16'd1);           // extends end of the zero range
		send_word(OP_ADD, VALUE_TOP - 16'd1); // extends start of the top range
		send_word(OP_ADD, 16'd100);
		send_word(OP_ADD, 16'd102);
		send_word(OP_ADD, 16'd101);         // joins the two
		send_word(OP_ADD, 16'd101);         // covered inside a joined range
		send_word(OP_ADD, 16'd99);          // extends start
		send_word(OP_ADD, 16'd103);         // extends end
		send_word(OP_ADD, 16'd3);
		send_word(OP_ADD, 16'd2);           // joins from the front of the table
		send_word(OP_DUMP, VALUE_WIDTH'($urandom));
		send_word(OP_ADD, 16'd50000);
		send_word(OP_DUMP, VALUE_TOP);

		// random phases until the word budget is used up
		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			calm <= (phase == 2);
			if (phase == 3) begin
				// fill the table with isolated values until adds get dropped
				base = $urandom_range(60000, 200);
				for (k = 0; k < FILL_STEPS; k++)
					send_word(OP_ADD, VALUE_WIDTH'(base + 2 * k));
				send_word(OP_DUMP, '0);
				send_word(OP_ADD, VALUE_WIDTH'(base - 1));   // extend while full
				send_word(OP_ADD, VALUE_WIDTH'(base + 1));   // join while full
				send_word(OP_ADD, VALUE_WIDTH'(base + 2 * FILL_STEPS + 7));
				send_word(OP_DUMP, '0);
			end else begin
				window_phase(phase == 2 ? 60 : $urandom_range(40, 20));
			end
			phase++;
		end
		calm       <= 1'b0;
		item_valid <= 1'b0;

		// drain, then give a dump or stray word time to show up
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.n_errors == 0 && sb.expected_q.size() == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
